/* sv/ptqs_pkg.sv */
package ptqs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_SERVICE = 8;

  localparam int ID_W   = 16;
  localparam int TICK_W = 32;
  localparam int PRI_W  = 3;
  localparam int SVC_W  = 4;
  localparam int QCNT_W = 5;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] arrival;
    logic [PRI_W-1:0]  pri;
  } slot_t;

  typedef struct packed {
    logic  step;
    logic  ins;
    logic  pop;
    slot_t new_slot;
  } ctl_t;

endpackage

/* sv/ptqs_cell.sv */
module ptqs_cell #(
  parameter int RW   = 4,
  parameter bit HEAD = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ptqs_pkg::ctl_t  ctl,
  input  logic [RW-1:0]   new_rem,
  input  ptqs_pkg::slot_t left_slot,
  input  logic [RW-1:0]   left_rem,
  input  logic            left_stay,
  input  ptqs_pkg::slot_t right_slot,
  input  logic [RW-1:0]   right_rem,
  input  logic            right_stay,
  output ptqs_pkg::slot_t slot,
  output logic [RW-1:0]   rem,
  output logic            stay,
  output ptqs_pkg::slot_t view_slot,
  output logic [RW-1:0]   view_rem
);
  import ptqs_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r;
  logic [TICK_W-1:0] arrival_r;
  logic [PRI_W-1:0]  pri_r;
  logic [RW-1:0]     rem_r, rem_nxt;
  slot_t             own_slot, next_slot, slot_nxt;
  logic [RW-1:0]     next_rem;

  assign own_slot = '{valid: valid_r, id: id_r, arrival: arrival_r, pri: pri_r};
  assign slot     = own_slot;
  assign rem      = rem_r;
  assign stay     = valid_r && (pri_r >= ctl.new_slot.pri);

  always_comb begin
    view_slot = own_slot;
    view_rem  = rem_r;
    next_slot = right_slot;
    next_rem  = right_rem;
    if (ctl.ins) begin
      if (!stay) begin
        view_slot = left_stay ? ctl.new_slot : left_slot;
        view_rem  = left_stay ? new_rem : left_rem;
      end
      if (!right_stay) begin
        next_slot = stay ? ctl.new_slot : own_slot;
        next_rem  = stay ? new_rem : rem_r;
      end
    end
    if (ctl.pop) begin
      slot_nxt = next_slot;
      rem_nxt  = next_rem;
    end else begin
      slot_nxt = view_slot;
      rem_nxt  = HEAD ? view_rem - RW'(1) : view_rem;
    end
    valid_nxt = slot_nxt.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      id_r      <= slot_nxt.id;
      arrival_r <= slot_nxt.arrival;
      pri_r     <= slot_nxt.pri;
      rem_r     <= rem_nxt;
    end
  end

endmodule

/* sv/priority_task_queue_server_unit.sv */
// The start pulse is registered into valid_r, which drives the out_valid strobe carrying that tick's result.
// Throughput: one tick per cycle; busy stays low, and the row of queue cells
// inserts, decrements the head and removes it, all in the same cycle.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Synchronous active-low reset empties the queue and clears tick, id and totals.
module priority_task_queue_server_unit #(
  parameter int QUEUE_DEPTH = ptqs_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_SERVICE = ptqs_pkg::DEF_MAX_SERVICE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_task_arrives,
  input  logic [ptqs_pkg::SVC_W-1:0]  in_service_ticks,
  input  logic [ptqs_pkg::PRI_W-1:0]  in_task_priority,
  output logic                        out_valid,
  output logic                        out_task_served,
  output logic [ptqs_pkg::ID_W-1:0]   out_served_id,
  output logic [ptqs_pkg::TICK_W-1:0] out_served_wait,
  output logic [ptqs_pkg::QCNT_W-1:0] out_queued_count,
  output logic                        out_arrival_dropped,
  output logic [ptqs_pkg::ID_W-1:0]   out_tasks_accepted,
  output logic [ptqs_pkg::TICK_W-1:0] out_wait_total
);
  import ptqs_pkg::*;

  localparam int RW = (MAX_SERVICE < 2) ? 1 : $clog2(MAX_SERVICE + 1);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (SVC_W > 9) ? SVC_W : 9;

  slot_t          cell_slot [QUEUE_DEPTH];
  logic [RW-1:0]  cell_rem  [QUEUE_DEPTH];
  logic           cell_stay [QUEUE_DEPTH];
  slot_t          cell_view [QUEUE_DEPTH];
  logic [RW-1:0]  cell_vrem [QUEUE_DEPTH];

  ctl_t              ctl;
  logic              step, full;
  logic [SW-1:0]     svc_fix;
  logic [RW-1:0]     new_rem;
  logic [TICK_W-1:0] tick_r, swait;
  logic [ID_W-1:0]   next_id_r, acc_r;
  logic [TICK_W-1:0] wsum_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              valid_r, served_r, dropped_r;
  logic [ID_W-1:0]   sid_r;
  logic [TICK_W-1:0] swait_r;

  assign busy = 1'b0;
  assign step = start && !busy;
  assign full = cell_slot[QUEUE_DEPTH-1].valid;

  always_comb begin
    svc_fix = SW'(in_service_ticks);
    if (svc_fix == '0) begin
      svc_fix = SW'(1);
    end
    if (svc_fix > SW'(MAX_SERVICE)) begin
      svc_fix = SW'(MAX_SERVICE);
    end
    new_rem = svc_fix[RW-1:0];
  end

  always_comb begin
    ctl.step             = step;
    ctl.ins              = step && in_task_arrives && !full;
    ctl.new_slot.valid   = 1'b1;
    ctl.new_slot.id      = next_id_r;
    ctl.new_slot.arrival = tick_r;
    ctl.new_slot.pri     = in_task_priority;
    ctl.pop              = step && cell_view[0].valid && (cell_vrem[0] == RW'(1));
  end

  assign swait = tick_r - cell_view[0].arrival;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t         l_slot, r_slot;
    logic [RW-1:0] l_rem, r_rem;
    logic          l_stay, r_stay;

    if (i == 0) begin : g_first
      assign l_slot = '0;
      assign l_rem  = '0;
      assign l_stay = 1'b1;
    end else begin : g_mid_l
      assign l_slot = cell_slot[i-1];
      assign l_rem  = cell_rem[i-1];
      assign l_stay = cell_stay[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_slot = '0;
      assign r_rem  = '0;
      assign r_stay = 1'b0;
    end else begin : g_mid_r
      assign r_slot = cell_slot[i+1];
      assign r_rem  = cell_rem[i+1];
      assign r_stay = cell_stay[i+1];
    end

    ptqs_cell #(
      .RW   (RW),
      .HEAD (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_rem    (new_rem),
      .left_slot  (l_slot),
      .left_rem   (l_rem),
      .left_stay  (l_stay),
      .right_slot (r_slot),
      .right_rem  (r_rem),
      .right_stay (r_stay),
      .slot       (cell_slot[i]),
      .rem        (cell_rem[i]),
      .stay       (cell_stay[i]),
      .view_slot  (cell_view[i]),
      .view_rem   (cell_vrem[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins && !ctl.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!ctl.ins && ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      next_id_r <= '0;
      acc_r     <= '0;
      wsum_r    <= '0;
      count_r   <= '0;
      valid_r   <= 1'b0;
      served_r  <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      valid_r <= step;
      if (step) begin
        tick_r    <= tick_r + TICK_W'(1);
        count_r   <= count_nxt;
        served_r  <= ctl.pop;
        dropped_r <= in_task_arrives && full;
        if (ctl.ins) begin
          next_id_r <= next_id_r + ID_W'(1);
          acc_r     <= acc_r + ID_W'(1);
        end
        if (ctl.pop) begin
          wsum_r <= wsum_r + swait;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sid_r   <= ctl.pop ? cell_view[0].id : '0;
      swait_r <= ctl.pop ? swait : '0;
    end
  end

  assign out_valid           = valid_r;
  assign out_task_served     = served_r;
  assign out_served_id       = sid_r;
  assign out_served_wait     = swait_r;
  assign out_queued_count    = QCNT_W'(count_r);
  assign out_arrival_dropped = dropped_r;
  assign out_tasks_accepted  = acc_r;
  assign out_wait_total      = wsum_r;

endmodule

/* sv/ptqs_checker.sv */
module ptqs_checker #(
  parameter int QUEUE_DEPTH = ptqs_pkg::DEF_QUEUE_DEPTH
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_task_served,
  input logic [ptqs_pkg::ID_W-1:0]   out_served_id,
  input logic [ptqs_pkg::TICK_W-1:0] out_served_wait,
  input logic [ptqs_pkg::QCNT_W-1:0] out_queued_count,
  input logic                        out_arrival_dropped,
  input logic [ptqs_pkg::TICK_W-1:0] out_wait_total
);
  import ptqs_pkg::*;

  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(start && !busy) |-> out_valid)
    else $error("result strobe missing after accepted item");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_served |-> (out_served_id == '0) && (out_served_wait == '0))
    else $error("served fields nonzero without a served task");

  a_total_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_served |-> $stable(out_wait_total))
    else $error("wait total moved without a served task");

  a_drop_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrival_dropped |->
      (out_queued_count == FULL_CNT) ||
      (out_task_served && (out_queued_count == FULL_CNT - QCNT_W'(1))))
    else $error("drop flagged while queue not full");

endmodule

bind priority_task_queue_server_unit ptqs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptqs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_task_served     (out_task_served),
  .out_served_id       (out_served_id),
  .out_served_wait     (out_served_wait),
  .out_queued_count    (out_queued_count),
  .out_arrival_dropped (out_arrival_dropped),
  .out_wait_total      (out_wait_total)
);
